FILE: hdl/scr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sequenced chunk reassembler.
// No dependencies; imported by every module of the block.
package scr_pkg;

	localparam int MAX_BUFFER   = 4096;
	localparam int HEADER_BYTES = 7;
	localparam int MAX_PACKET   = 250;

	localparam int CAP_W   = 13;
	localparam int LEN_W   = 12;
	localparam int BYTE_W  = 8;
	localparam int SEQ_W   = 16;
	localparam int TOTAL_W = 32;
	localparam int MODE_W  = 2;
	localparam int IDX_W   = 2;

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [MODE_W-1:0] MODE_BYTE   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ARM    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DISARM = 2'd2;

	localparam logic [IDX_W-1:0] REG_CAPACITY = 2'd0;
	localparam logic [IDX_W-1:0] REG_START    = 2'd1;
	localparam logic [IDX_W-1:0] REG_CHUNK    = 2'd2;
	localparam logic [IDX_W-1:0] REG_END      = 2'd3;

	localparam logic [CAP_W-1:0]  CAP_MAX   = CAP_W'(MAX_BUFFER);
	localparam logic [BYTE_W-1:0] HDR_LEN   = BYTE_W'(HEADER_BYTES);
	localparam logic [BYTE_W-1:0] HDR_LAST  = BYTE_W'(HEADER_BYTES - 1);
	localparam logic [BYTE_W-1:0] PKT_MAX   = BYTE_W'(MAX_PACKET);

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_TERM  = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		CLS_NONE  = 4'b0001,
		CLS_START = 4'b0010,
		CLS_CHUNK = 4'b0100,
		CLS_END   = 4'b1000
	} pkt_class_t;

	// One queue entry: the results caused by one input byte.
	typedef struct packed {
		logic               wr;
		logic [BYTE_W-1:0]  wr_data;
		logic [LEN_W-1:0]   wr_addr;
		logic               end_en;
		kind_t              end_kind;
		logic [LEN_W-1:0]   end_len;
		logic [TOTAL_W-1:0] total;
	} cmd_t;

endpackage

FILE: hdl/scr_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, packet header parsing and reassembly state.
// Produces one queue entry per byte that causes results. Depends on scr_pkg.
module scr_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [scr_pkg::IDX_W-1:0]    cfg_index,
	input  logic [scr_pkg::CAP_W-1:0]    cfg_data,
	input  logic                         take,
	input  logic [scr_pkg::MODE_W-1:0]   mode,
	input  logic [scr_pkg::BYTE_W-1:0]   data_byte,
	input  logic                         first_byte,
	input  logic [scr_pkg::BYTE_W-1:0]   packet_length,
	output logic                         rec_valid,
	output scr_pkg::cmd_t                rec
);
	import scr_pkg::*;

	logic [CAP_W-1:0]   capacity_q;
	logic [BYTE_W-1:0]  start_code_q, chunk_code_q, end_code_q;
	logic [BYTE_W-1:0]  bp_q, cl_q, ptype_q;
	logic [SEQ_W-1:0]   pseq_q, exp_q;
	logic [TOTAL_W-1:0] staged_q, total_q;
	logic [LEN_W-1:0]   rl_q;
	logic               armed_q, acc_q;
	pkt_class_t         cls_q;

	logic [CAP_W-1:0]   cap;
	logic [BYTE_W-1:0]  len_clamp, bp_eff, cl_eff, pos, plen;
	logic               acc_eff, is_byte, active, wr, hdr_done, end_en;
	pkt_class_t         cls_eff, cls_new;
	logic               acc_new;
	logic [SEQ_W-1:0]   exp_new;
	logic [TOTAL_W-1:0] total_new, staged_full;
	logic [LEN_W-1:0]   rl_new;

	always_comb begin
		cap = (capacity_q > CAP_MAX) ? CAP_MAX : capacity_q;
		len_clamp = (packet_length > PKT_MAX) ? PKT_MAX : packet_length;
		if (len_clamp < HDR_LEN) begin
			len_clamp = '0;
		end
		bp_eff  = first_byte ? '0 : bp_q;
		cl_eff  = first_byte ? len_clamp : cl_q;
		acc_eff = first_byte ? 1'b0 : acc_q;
		cls_eff = first_byte ? CLS_NONE : cls_q;

		is_byte  = (mode == MODE_BYTE);
		active   = is_byte && (bp_eff < cl_eff);
		pos      = bp_eff;
		plen     = cl_eff - HDR_LEN;
		hdr_done = active && (pos == HDR_LAST);
		staged_full = {data_byte, staged_q[23:0]};

		wr = active && (pos >= HDR_LEN) && acc_eff && (({1'b0, rl_q} + CAP_W'(1)) < cap);

		cls_new   = cls_eff;
		acc_new   = acc_eff;
		exp_new   = exp_q;
		total_new = total_q;
		rl_new    = wr ? rl_q + LEN_W'(1) : rl_q;
		// header is complete on its last byte: classify the packet
		if (hdr_done) begin
			acc_new = 1'b0;
			if (ptype_q == start_code_q) begin
				cls_new   = CLS_START;
				total_new = staged_full;
				rl_new    = '0;
				acc_new   = armed_q && (plen != '0) && ({5'b0, plen} < cap);
				exp_new   = pseq_q + SEQ_W'(1);
			end else if (ptype_q == chunk_code_q) begin
				cls_new = CLS_CHUNK;
				if ((pseq_q == exp_q) && armed_q && (plen != '0)) begin
					acc_new = 1'b1;
					exp_new = pseq_q + SEQ_W'(1);
				end
			end else if (ptype_q == end_code_q) begin
				cls_new = CLS_END;
				acc_new = armed_q && (plen != '0);
			end else begin
				cls_new = CLS_NONE;
			end
		end
		end_en = active && ((pos + BYTE_W'(1)) == cl_eff) && (cls_new == CLS_END);

		rec.wr       = wr;
		rec.wr_data  = data_byte;
		rec.wr_addr  = rl_q;
		rec.end_en   = end_en;
		rec.end_kind = (armed_q && ({1'b0, rl_new} < cap)) ? KIND_TERM : KIND_DONE;
		rec.end_len  = rl_new;
		rec.total    = total_new;
		rec_valid    = take && (wr || end_en);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q   <= CAP_MAX;
			start_code_q <= 8'd0;
			chunk_code_q <= 8'd1;
			end_code_q   <= 8'd2;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_CAPACITY: capacity_q   <= cfg_data;
				REG_START:    start_code_q <= cfg_data[BYTE_W-1:0];
				REG_CHUNK:    chunk_code_q <= cfg_data[BYTE_W-1:0];
				REG_END:      end_code_q   <= cfg_data[BYTE_W-1:0];
				default:      capacity_q   <= capacity_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_q     <= '0;
			cl_q     <= '0;
			ptype_q  <= '0;
			pseq_q   <= '0;
			staged_q <= '0;
			total_q  <= '0;
			rl_q     <= '0;
			exp_q    <= '0;
			armed_q  <= 1'b0;
			acc_q    <= 1'b0;
			cls_q    <= CLS_NONE;
		end else if (take) begin
			case (mode)
				MODE_ARM: begin
					rl_q    <= '0;
					total_q <= '0;
					exp_q   <= '0;
					armed_q <= 1'b1;
					bp_q    <= cl_q;
					acc_q   <= 1'b0;
				end
				MODE_DISARM: begin
					armed_q <= 1'b0;
					bp_q    <= cl_q;
					acc_q   <= 1'b0;
				end
				MODE_BYTE: begin
					bp_q    <= active ? pos + BYTE_W'(1) : bp_eff;
					cl_q    <= cl_eff;
					acc_q   <= acc_new;
					cls_q   <= cls_new;
					rl_q    <= rl_new;
					total_q <= total_new;
					exp_q   <= exp_new;
					if (active) begin
						case (pos)
							8'd0:    ptype_q <= data_byte;
							8'd1:    pseq_q  <= {8'd0, data_byte};
							8'd2:    pseq_q  <= {data_byte, pseq_q[7:0]};
							8'd3:    staged_q <= {24'd0, data_byte};
							8'd4:    staged_q <= {16'd0, data_byte, staged_q[7:0]};
							8'd5:    staged_q <= {8'd0, data_byte, staged_q[15:0]};
							8'd6:    staged_q <= staged_full;
							default: staged_q <= staged_q;
						endcase
					end
				end
				default: bp_q <= bp_q;
			endcase
		end
	end

endmodule

FILE: hdl/scr_queue.sv
`timescale 1ns / 1ps
// Small register queue between front end and result stage.
// Holds cmd_t entries; depth from scr_pkg::QDEPTH.
module scr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  scr_pkg::cmd_t wr_rec,
	input  logic          rd,
	output logic          full,
	output logic          rd_valid,
	output scr_pkg::cmd_t rd_rec
);
	import scr_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr, do_rd;

	assign full     = (count_q == QCNT_W'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_rec   = mem_q[rd_ptr_q];
	assign do_wr    = wr && !full;
	assign do_rd    = rd && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count exceeds depth");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> !full)
		else $error("entry offered to a full queue");

endmodule

FILE: hdl/scr_back.sv
`timescale 1ns / 1ps
// Result stage: splits a queue entry into one or two results and holds the
// current one in an output register. Depends on scr_pkg.
module scr_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  scr_pkg::cmd_t                q_rec,
	output logic                         q_pop,
	input  logic                         pop,
	output logic                         empty,
	output logic [1:0]                   kind,
	output logic [scr_pkg::LEN_W-1:0]    write_address,
	output logic [scr_pkg::BYTE_W-1:0]   write_data,
	output logic [scr_pkg::LEN_W-1:0]    final_length,
	output logic [scr_pkg::TOTAL_W-1:0]  declared_total,
	output logic                         last
);
	import scr_pkg::*;

	logic               out_valid_q, half_q, last_q;
	kind_t              kind_q;
	logic [LEN_W-1:0]   addr_q, fin_q;
	logic [BYTE_W-1:0]  data_q;
	logic [TOTAL_W-1:0] total_q;
	logic               load, take_write;

	assign load       = !out_valid_q || pop;
	// payload write goes out first when an entry carries both results
	assign take_write = q_rec.wr && !half_q;
	assign q_pop      = load && q_valid && !(take_write && q_rec.end_en);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			half_q      <= 1'b0;
		end else if (load) begin
			out_valid_q <= q_valid;
			if (q_valid) begin
				half_q <= take_write && q_rec.end_en;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && q_valid) begin
			total_q <= q_rec.total;
			if (take_write) begin
				kind_q <= KIND_WRITE;
				addr_q <= q_rec.wr_addr;
				data_q <= q_rec.wr_data;
				fin_q  <= q_rec.wr_addr;
				last_q <= !q_rec.end_en;
			end else begin
				kind_q <= q_rec.end_kind;
				addr_q <= q_rec.end_len;
				data_q <= '0;
				fin_q  <= q_rec.end_len;
				last_q <= 1'b1;
			end
		end
	end

	assign empty          = !out_valid_q;
	assign kind           = kind_q;
	assign write_address  = addr_q;
	assign write_data     = data_q;
	assign final_length   = fin_q;
	assign declared_total = total_q;
	assign last           = last_q;

	a_half_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> q_valid)
		else $error("second half pending without a queue entry");

	a_first_is_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q) |-> (kind_q == KIND_WRITE))
		else $error("non-final result is not a payload write");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q && pop) |=> (out_valid_q && last_q && kind_q != KIND_WRITE))
		else $error("completion did not follow the payload write of its pair");

endmodule

FILE: hdl/sequenced_chunk_reassembler_top.sv
`timescale 1ns / 1ps
// Top level of the sequenced chunk reassembler.
// Instantiates scr_front, scr_queue and scr_back; uses scr_pkg.
//
// Usage:
//   Input channel: present mode/data_byte/first_byte/packet_length with push;
//   a transaction completes on a clock edge with push high and full low.
//   One item per cycle is taken while full is low; mode items and ignored bytes cause nothing.
//   Result channel: while empty is low the oldest result is on the ports;
//   pop high on an edge with empty low takes it. Each input byte causes at
//   most two results (payload write, then completion on the last byte of an
//   end packet); last marks the final result of an input.
//   A result is registered in the queue and then in the output register
//   before it shows on the ports. While the receiver pops, the result side
//   delivers one result per cycle,
//   so sustained input rate is one byte per cycle except when an end packet's
//   last byte adds a second result; the four-entry queue absorbs that and
//   full rises only when the receiver stalls or lags behind.
//   A stalled receiver holds the current result steady; the queue fills and
//   then full holds off the sender, nothing is lost.
//   Configuration: cfg_write with cfg_index/cfg_data writes one register at
//   the edge; write only while the block is idle.
//   Reset (arst_n low) restores register defaults, clears reassembly state,
//   disarms and empties the queue.
module sequenced_chunk_reassembler_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [scr_pkg::IDX_W-1:0]    cfg_index,
	input  logic [scr_pkg::CAP_W-1:0]    cfg_data,
	input  logic                         push,
	output logic                         full,
	input  logic [scr_pkg::MODE_W-1:0]   mode,
	input  logic [scr_pkg::BYTE_W-1:0]   data_byte,
	input  logic                         first_byte,
	input  logic [scr_pkg::BYTE_W-1:0]   packet_length,
	output logic                         empty,
	input  logic                         pop,
	output logic [1:0]                   kind,
	output logic [scr_pkg::LEN_W-1:0]    write_address,
	output logic [scr_pkg::BYTE_W-1:0]   write_data,
	output logic [scr_pkg::LEN_W-1:0]    final_length,
	output logic [scr_pkg::TOTAL_W-1:0]  declared_total,
	output logic                         last
);
	import scr_pkg::*;

	logic take, rec_valid, q_valid, q_pop;
	cmd_t rec, q_rec;

	assign take = push && !full;

	scr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.take          (take),
		.mode          (mode),
		.data_byte     (data_byte),
		.first_byte    (first_byte),
		.packet_length (packet_length),
		.rec_valid     (rec_valid),
		.rec           (rec)
	);

	scr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (rec_valid),
		.wr_rec   (rec),
		.rd       (q_pop),
		.full     (full),
		.rd_valid (q_valid),
		.rd_rec   (q_rec)
	);

	scr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_rec          (q_rec),
		.q_pop          (q_pop),
		.pop            (pop),
		.empty          (empty),
		.kind           (kind),
		.write_address  (write_address),
		.write_data     (write_data),
		.final_length   (final_length),
		.declared_total (declared_total),
		.last           (last)
	);

endmodule

FILE: dv/tb_sequenced_chunk_reassembler_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for sequenced_chunk_reassembler_top: directed rows, then random
// packet traffic over several register settings, scored against an in-bench predictor.
// Depends on scr_pkg and the RTL under hdl/.
module tb_sequenced_chunk_reassembler_top;
	import scr_pkg::*;

	localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;	// no-op mode, must be ignored
	localparam int N_PHASES      = 8;
	localparam int PHASE_BYTES   = 190;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 1000000;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [7:0]        data;
		logic              first;
		logic [7:0]        plen;
	} rx_byte_t;

	typedef struct packed {
		kind_t       kind;
		logic [11:0] addr;
		logic [7:0]  data;
		logic [11:0] length;
		logic [31:0] total;
		logic        last;
	} buf_op_t;

	typedef struct packed {
		rx_byte_t item;
		logic     pinned;	// op below is the expected result, typed in by hand
		buf_op_t  op;
	} directed_row_t;

	localparam buf_op_t NO_OP = '{KIND_WRITE, 12'd0, 8'd0, 12'd0, 32'd0, 1'b0};

	localparam directed_row_t DIRECTED_ROWS [25] = '{
		'{'{MODE_ARM,  8'h00, 1'b0, 8'd0}, 1'b0, NO_OP},
		// start, seq 0xffff, total 0xffffffff, no payload
		'{'{MODE_BYTE, 8'h00, 1'b1, 8'd7}, 1'b0, NO_OP},
		'{'{MODE_BYTE, 8'hFF, 1'b0, 8'd0}, 1'b0, NO_OP},
		'{'{MODE_BYTE, 8'hFF, 1'b0, 8'd0}, 1'b0, NO_OP},
		'{'{MODE_BYTE, 8'hFF, 1'b0, 8'd0}, 1'b0, NO_OP},
		'{'{MODE_BYTE, 8'hFF, 1'b0, 8'd0}, 1'b0, NO_OP},
		'{'{MODE_BYTE, 8'hFF, 1'b0, 8'd0}, 1'b0, NO_OP},
		'{'{MODE_BYTE, 8'hFF, 1'b0, 8'd0}, 1'b0, NO_OP},
		// chunk, seq wraps to 0, one payload byte
		'{'{MODE_BYTE, 8'h01, 1'b1, 8'd8}, 1'b0, NO_OP},
		'{'{MODE_BYTE, 8'h00, 1'b0, 8'd0}, 1'b0, NO_OP},
		'{'{MODE_BYTE, 8'h00, 1'b0, 8'd0}, 1'b0, NO_OP},
		'{'{MODE_BYTE, 8'h00, 1'b0, 8'd0}, 1'b0, NO_OP},
		'{'{MODE_BYTE, 8'h00, 1'b0, 8'd0}, 1'b0, NO_OP},
		'{'{MODE_BYTE, 8'h00, 1'b0, 8'd0}, 1'b0, NO_OP},
		'{'{MODE_BYTE, 8'h00, 1'b0, 8'd0}, 1'b0, NO_OP},
		'{'{MODE_BYTE, 8'hFF, 1'b0, 8'd0}, 1'b1,
			'{KIND_WRITE, 12'd0, 8'hFF, 12'd0, 32'hFFFF_FFFF, 1'b1}},
		// end, header only
		'{'{MODE_BYTE, 8'h02, 1'b1, 8'd7}, 1'b0, NO_OP},
		'{'{MODE_BYTE, 8'h00, 1'b0, 8'd0}, 1'b0, NO_OP},
		'{'{MODE_BYTE, 8'h00, 1'b0, 8'd0}, 1'b0, NO_OP},
		'{'{MODE_BYTE, 8'h00, 1'b0, 8'd0}, 1'b0, NO_OP},
		'{'{MODE_BYTE, 8'h00, 1'b0, 8'd0}, 1'b0, NO_OP},
		'{'{MODE_BYTE, 8'h00, 1'b0, 8'd0}, 1'b0, NO_OP},
		'{'{MODE_BYTE, 8'h00, 1'b0, 8'd0}, 1'b1,
			'{KIND_TERM, 12'd1, 8'h00, 12'd1, 32'hFFFF_FFFF, 1'b1}},
		'{'{MODE_DISARM, 8'h00, 1'b0, 8'd0}, 1'b0, NO_OP},
		// zero length: packet ignored
		'{'{MODE_BYTE, 8'h5A, 1'b1, 8'd0}, 1'b0, NO_OP}
	};

	localparam int          PHASE_CAP   [N_PHASES] = '{4096, 1, 24, 0, 8191, 40, 0, 4097};
	localparam logic [7:0]  PHASE_START [N_PHASES] = '{8'h00, 8'hFF, 8'h10, 8'h02,
		8'h03, 8'h09, 8'h00, 8'h55};
	localparam logic [7:0]  PHASE_CHUNK [N_PHASES] = '{8'h01, 8'h00, 8'h11, 8'h01,
		8'h03, 8'h04, 8'h00, 8'hAA};
	localparam logic [7:0]  PHASE_END   [N_PHASES] = '{8'h02, 8'h80, 8'h12, 8'h00,
		8'h03, 8'h04, 8'h00, 8'h00};

	logic              clk;
	logic              arst_n;
	logic              cfg_write;
	logic [IDX_W-1:0]  cfg_index;
	logic [CAP_W-1:0]  cfg_data;
	logic              push;
	logic              full;
	logic [MODE_W-1:0] mode;
	logic [7:0]        data_byte;
	logic              first_byte;
	logic [7:0]        packet_length;
	logic              empty;
	logic              pop;
	logic [1:0]        kind;
	logic [11:0]       write_address;
	logic [7:0]        write_data;
	logic [11:0]       final_length;
	logic [31:0]       declared_total;
	logic              last;

	sequenced_chunk_reassembler_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.mode           (mode),
		.data_byte      (data_byte),
		.first_byte     (first_byte),
		.packet_length  (packet_length),
		.empty          (empty),
		.pop            (pop),
		.kind           (kind),
		.write_address  (write_address),
		.write_data     (write_data),
		.final_length   (final_length),
		.declared_total (declared_total),
		.last           (last)
	);

	// predictor copy of registers and reassembly state
	logic [12:0] cap_reg;
	logic [7:0]  start_code, chunk_code, end_code;
	int          pos_cnt, pkt_len, rcv_len;
	logic [7:0]  pkt_type;
	logic [15:0] pkt_seq, next_seq_due;
	logic [31:0] total_shown, total_staged;
	logic        is_armed, taking_payload;
	pkt_class_t  pkt_class;

	buf_op_t     step_ops [$];
	buf_op_t     buf_ops_due [$];

	logic [15:0] next_seq;	// sequence the generator believes comes next
	logic        idle_on;
	logic        hold_request;
	int          effective_bytes, mismatches, writes_seen, completions_seen;
	int          stalled_cycles, holds_done, cycle_count, settings_used;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
				buf_ops_due.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int pick_payload();
		int r = $urandom_range(0, 99);
		if (r < 75) return $urandom_range(0, 6);
		if (r < 95) return $urandom_range(7, 24);
		if (r < 98) return $urandom_range(25, 243);
		return $urandom_range(244, 248);	// length field beyond the packet limit
	endfunction

	// Buffer operations caused by one received byte; returns 1 if the byte was used.
	function automatic bit reassemble_byte(input rx_byte_t b);
		buf_op_t found [2];
		int      n, at, room, span;
		n = 0;
		step_ops.delete();
		if (b.mode == MODE_ARM || b.mode == MODE_DISARM) begin
			if (b.mode == MODE_ARM) begin
				rcv_len = 0;
				total_shown = '0;
				next_seq_due = '0;
				is_armed = 1'b1;
			end else begin
				is_armed = 1'b0;
			end
			pos_cnt = pkt_len;
			taking_payload = 1'b0;
			return 1'b1;
		end
		if (b.mode != MODE_BYTE) return 1'b0;
		if (b.first) begin
			pkt_len = (b.plen > PKT_MAX) ? MAX_PACKET : int'(b.plen);
			if (pkt_len < HEADER_BYTES) pkt_len = 0;
			pos_cnt = 0;
			taking_payload = 1'b0;
			pkt_class = CLS_NONE;
		end
		if (pos_cnt >= pkt_len) return 1'b0;
		at = pos_cnt;
		pos_cnt++;
		room = (cap_reg > CAP_MAX) ? MAX_BUFFER : int'(cap_reg);

		if (at == 0) begin
			pkt_type = b.data;
		end else if (at == 1) begin
			pkt_seq = {8'h00, b.data};
		end else if (at == 2) begin
			pkt_seq[15:8] = b.data;
		end else if (at < HEADER_BYTES) begin
			if (at == 3) total_staged = '0;
			total_staged[8*(at-3) +: 8] = b.data;
		end else if (taking_payload && rcv_len + 1 < room) begin
			found[n] = '{KIND_WRITE, 12'(rcv_len), b.data, 12'(rcv_len), total_shown, 1'b0};
			n++;
			rcv_len++;
		end

		if (at == HEADER_BYTES - 1) begin
			span = pkt_len - HEADER_BYTES;
			taking_payload = 1'b0;
			// start beats chunk, chunk beats end when codes coincide
			if (pkt_type == start_code) begin
				pkt_class = CLS_START;
				total_shown = total_staged;
				rcv_len = 0;
				taking_payload = is_armed && span > 0 && span < room;
				next_seq_due = pkt_seq + 16'd1;
			end else if (pkt_type == chunk_code) begin
				pkt_class = CLS_CHUNK;
				if (pkt_seq == next_seq_due && is_armed && span > 0) begin
					taking_payload = 1'b1;
					next_seq_due = pkt_seq + 16'd1;
				end
			end else if (pkt_type == end_code) begin
				pkt_class = CLS_END;
				taking_payload = is_armed && span > 0;
			end else begin
				pkt_class = CLS_NONE;
			end
		end

		if (at + 1 == pkt_len && pkt_class == CLS_END) begin
			if (is_armed && rcv_len < room)
				found[n] = '{KIND_TERM, 12'(rcv_len), 8'h00, 12'(rcv_len), total_shown, 1'b0};
			else
				found[n] = '{KIND_DONE, 12'(rcv_len), 8'h00, 12'(rcv_len), total_shown, 1'b0};
			n++;
		end

		for (int k = 0; k < n; k++) begin
			found[k].last = (k == n - 1);
			step_ops.push_back(found[k]);
		end
		return 1'b1;
	endfunction

	task automatic drive_item(input rx_byte_t b);
		int gap;
		gap = idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push          <= 1'b1;
		mode          <= b.mode;
		data_byte     <= b.data;
		first_byte    <= b.first;
		packet_length <= b.plen;
		do @(posedge clk); while (full);
	endtask

	task automatic send_item(input rx_byte_t b);
		drive_item(b);
		if (reassemble_byte(b)) effective_bytes++;
		foreach (step_ops[k]) buf_ops_due.push_back(step_ops[k]);
	endtask

	task automatic send_mode(input logic [MODE_W-1:0] m);
		rx_byte_t b;
		b.mode  = m;
		b.data  = 8'($urandom);
		b.first = 1'($urandom);
		b.plen  = 8'($urandom);
		send_item(b);
	endtask

	task automatic send_packet(input logic [7:0] ptype, input logic [15:0] seq,
			input logic [31:0] tot, input int len_field, input int nbytes);
		logic [7:0] hdr [7];
		rx_byte_t   b;
		hdr = '{ptype, seq[7:0], seq[15:8], tot[7:0], tot[15:8], tot[23:16], tot[31:24]};
		for (int i = 0; i < nbytes; i++) begin
			b.mode  = MODE_BYTE;
			b.first = (i == 0);
			b.plen  = (i == 0) ? 8'(len_field) : 8'($urandom);
			if (i < HEADER_BYTES)
				b.data = hdr[i];
			else
				b.data = 8'($urandom);
			send_item(b);
		end
	endtask

	task automatic send_chunk();
		logic [15:0] seq;
		int          len;
		len = HEADER_BYTES + pick_payload();
		if ($urandom_range(0, 7) == 0) begin
			seq = next_seq + 16'($urandom_range(1, 65535));	// out of order
		end else begin
			seq = next_seq;
			next_seq++;
		end
		send_packet(chunk_code, seq, $urandom, len, len);
	endtask

	task automatic send_end();
		int len;
		len = HEADER_BYTES + $urandom_range(0, 6);
		send_packet(end_code, 16'($urandom), $urandom, len, len);
	endtask

	task automatic send_transfer();
		logic [15:0] seq;
		int          len;
		if ($urandom_range(0, 9) != 0) send_mode(MODE_ARM);
		seq = 16'($urandom);
		len = HEADER_BYTES + pick_payload();
		send_packet(start_code, seq, $urandom, len, len);
		next_seq = seq + 16'd1;
		repeat ($urandom_range(0, 3)) send_chunk();
		if ($urandom_range(0, 7) == 0) send_mode(MODE_DISARM);
		send_end();
	endtask

	task automatic send_noise();
		logic [7:0] t;
		int         len;
		do t = 8'($urandom); while (t == start_code || t == chunk_code || t == end_code);
		len = HEADER_BYTES + pick_payload();
		case ($urandom_range(0, 6))
			0: begin
				send_packet(8'($urandom), 16'($urandom), $urandom, $urandom_range(0, 6),
					$urandom_range(1, 8));
			end
			1: begin
				repeat ($urandom_range(1, 3)) begin
					send_item('{MODE_BYTE, 8'($urandom), 1'b0, 8'($urandom)});
				end
			end
			2: begin
				send_mode(MODE_NOP);
			end
			3: begin
				send_packet(t, 16'($urandom), $urandom, len, len);
			end
			4: begin
				// mode item in the middle of a packet, then leftover bytes
				send_packet(($urandom_range(0, 1) != 0) ? start_code : chunk_code, next_seq,
					$urandom, len, $urandom_range(1, len));
				send_mode(($urandom_range(0, 1) != 0) ? MODE_ARM : MODE_DISARM);
				repeat ($urandom_range(1, 3)) begin
					send_item('{MODE_BYTE, 8'($urandom), 1'b0, 8'($urandom)});
				end
			end
			5: begin
				// cut short by the next first byte
				send_packet(($urandom_range(0, 1) != 0) ? chunk_code : end_code, next_seq,
					$urandom, len, $urandom_range(1, len - 1));
			end
			default: begin
				send_mode(MODE_DISARM);
				send_end();
			end
		endcase
	endtask

	task automatic write_registers(input int cap, input logic [7:0] s_code,
			input logic [7:0] c_code, input logic [7:0] e_code);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_CAPACITY;
		cfg_data  <= CAP_W'(cap);
		@(negedge clk);
		cfg_index <= REG_START;
		cfg_data  <= {5'd0, s_code};
		@(negedge clk);
		cfg_index <= REG_CHUNK;
		cfg_data  <= {5'd0, c_code};
		@(negedge clk);
		cfg_index <= REG_END;
		cfg_data  <= {5'd0, e_code};
		@(negedge clk);
		cfg_write <= 1'b0;
		cap_reg    = CAP_W'(cap);
		start_code = s_code;
		chunk_code = c_code;
		end_code   = e_code;
		settings_used++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		push <= 1'b0;
		while (buf_ops_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		buf_op_t want;
		if (arst_n && push && full) stalled_cycles++;
		if (arst_n && pop && !empty) begin
			if (buf_ops_due.size() == 0) begin
				$error("result with nothing expected: kind %0d, address %0d", kind,
					write_address);
				mismatches++;
			end else begin
				want = buf_ops_due.pop_front();
				check_field("kind", 32'(want.kind), 32'(kind));
				check_field("write_address", 32'(want.addr), 32'(write_address));
				check_field("write_data", 32'(want.data), 32'(write_data));
				check_field("final_length", 32'(want.length), 32'(final_length));
				check_field("declared_total", want.total, declared_total);
				check_field("last", 32'(want.last), 32'(last));
			end
			if (kind == KIND_WRITE)
				writes_seen++;
			else
				completions_seen++;
		end
	end

	// result side: random pop gaps, plus long hold-offs on request
	initial begin
		int rx_gap;
		rx_gap = 0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				pop <= 1'b0;
				for (int n = 1; n < HOLD_CYCLES; n++) @(negedge clk);
				holds_done++;
			end else if (rx_gap > 0) begin
				pop <= 1'b0;
				rx_gap--;
			end else begin
				pop <= 1'b1;
				rx_gap = idle_on ? pick_gap() : 0;
			end
		end
	end

	initial begin
		int cap;
		logic [7:0] s_code, c_code, e_code;
		arst_n        = 1'b0;
		push          = 1'b0;
		mode          = MODE_BYTE;
		data_byte     = '0;
		first_byte    = 1'b0;
		packet_length = '0;
		cfg_write     = 1'b0;
		cfg_index     = REG_CAPACITY;
		cfg_data      = '0;
		hold_request  = 1'b0;
		idle_on       = 1'b1;
		next_seq      = '0;
		cap_reg       = CAP_MAX;
		start_code    = 8'h00;
		chunk_code    = 8'h01;
		end_code      = 8'h02;
		pos_cnt       = 0;
		pkt_len       = 0;
		rcv_len       = 0;
		pkt_type      = '0;
		pkt_seq       = '0;
		next_seq_due  = '0;
		total_shown   = '0;
		total_staged  = '0;
		is_armed      = 1'b0;
		taking_payload = 1'b0;
		pkt_class     = CLS_NONE;
		settings_used = 1;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
			drive_item(DIRECTED_ROWS[i].item);
			if (reassemble_byte(DIRECTED_ROWS[i].item)) effective_bytes++;
			if (DIRECTED_ROWS[i].pinned)
				buf_ops_due.push_back(DIRECTED_ROWS[i].op);
			else
				foreach (step_ops[k]) buf_ops_due.push_back(step_ops[k]);
		end

		for (int phase = 0; phase < N_PHASES; phase++) begin
			wait_idle();
			if (phase != 0) begin
				cap    = PHASE_CAP[phase];
				s_code = PHASE_START[phase];
				c_code = PHASE_CHUNK[phase];
				e_code = PHASE_END[phase];
				if (phase == 6) begin
					cap    = $urandom_range(2, 64);
					s_code = 8'($urandom);
					c_code = 8'($urandom);
					e_code = 8'($urandom);
				end
				write_registers(cap, s_code, c_code, e_code);
			end
			idle_on = ($urandom_range(0, 3) != 0);
			if (phase == 1 || phase == 5) hold_request = 1'b1;
			// carry on the previous transfer under the new setting
			if (phase != 0) begin
				repeat ($urandom_range(1, 2)) send_chunk();
				send_end();
			end
			while (effective_bytes < $size(DIRECTED_ROWS) + PHASE_BYTES * (phase + 1)) begin
				if ($urandom_range(0, 99) < 80)
					send_transfer();
				else
					send_noise();
			end
		end
		wait_idle();

		$display("Scored %0d buffer writes and %0d completions from %0d used bytes, %0d settings",
			writes_seen, completions_seen, effective_bytes, settings_used);
		$display("Input held off by full on %0d cycles; %0d long result hold-offs",
			stalled_cycles, holds_done);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hdl/scr_pkg.sv
hdl/scr_front.sv
hdl/scr_queue.sv
hdl/scr_back.sv
hdl/sequenced_chunk_reassembler_top.sv
dv/tb_sequenced_chunk_reassembler_top.sv
